/* src/sds_pkg.sv */
// Package for the SCAN disk scheduler: widths, reset values, controller states,
// and the command and status structs that join the controller and the datapath.
// It depends on nothing else.
package sds_pkg;

	localparam int TRACK_W           = 16;
	localparam int SEEK_W            = 20;
	localparam int TRACK_COUNT_W     = 17;
	localparam int MAX_REQUESTS_DEF  = 8;

	localparam logic [TRACK_COUNT_W-1:0] TRACK_COUNT_RESET = 17'd200;
	localparam logic [SEEK_W-1:0]        SEEK_MAX          = '1;

	// Sweep direction codes.
	localparam logic DIR_DOWN = 1'b0;
	localparam logic DIR_UP   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MERGE,
		ST_TAKE
	} sds_state_t;

	typedef struct packed {
		logic accept_item;
		logic begin_batch;
		logic scan_go;
		logic merge;
		logic take;
		logic next_pass;
		logic finish;
	} sds_cmd_t;

	typedef struct packed {
		logic scan_idle;
		logic found;
		logic last_pass;
	} sds_status_t;

endpackage

/* src/sds_ctrl.sv */
// Controller state machine of the SCAN disk scheduler.
// Depends on sds_pkg for the state enum and the command and status structs.
module sds_ctrl
	import sds_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        batch_end,
	input  sds_status_t status,
	output sds_cmd_t    cmd,
	output logic        busy
);

	sds_state_t state_q;
	sds_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept_item = 1'b1;
					if (batch_end) begin
						cmd.begin_batch = 1'b1;
						cmd.scan_go     = 1'b1;
						state_d         = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (status.scan_idle) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				cmd.merge = 1'b1;
				state_d   = ST_TAKE;
			end
			ST_TAKE: begin
				priority if (status.found) begin
					cmd.take    = 1'b1;
					cmd.scan_go = 1'b1;
					state_d     = ST_SCAN;
				end else if (!status.last_pass) begin
					cmd.next_pass = 1'b1;
					cmd.scan_go   = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/sds_datapath.sv */
// Datapath of the SCAN disk scheduler: request store, selection scan, seek
// accumulator and result registers. Depends on sds_pkg; driven by sds_ctrl.
module sds_datapath
	import sds_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sds_cmd_t                 cmd,
	output sds_status_t              status,
	input  logic                     cfg_we,
	input  logic [TRACK_COUNT_W-1:0] cfg_data,
	input  logic [TRACK_W-1:0]       request_track,
	input  logic [TRACK_W-1:0]       head_track,
	input  logic                     start_dir,
	output logic                     visit_valid,
	output logic [TRACK_W-1:0]       visit_track,
	output logic [SEEK_W-1:0]        seek_total,
	output logic                     seq_last
);

	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	logic [TRACK_W-1:0]       req_mem [MAX_REQUESTS];
	logic [TRACK_COUNT_W-1:0] track_count_q;
	logic [CW-1:0]            count_q;
	logic [MAX_REQUESTS-1:0]  used_q;
	logic                     end_used_q;
	logic                     pass_q;
	logic                     dir_q;
	logic [TRACK_W-1:0]       head_q;
	logic [TRACK_W-1:0]       end_q;
	logic [TRACK_W-1:0]       pos_q;
	logic [SEEK_W-1:0]        total_q;

	logic                     rd_run_q;
	logic [CW-1:0]            rd_idx_q;
	logic                     valid_s1;
	logic [IW-1:0]            idx_s1;
	logic [TRACK_W-1:0]       rdata_s1;

	logic                     found_q;
	logic [TRACK_W-1:0]       best_track_q;
	logic [IW-1:0]            best_idx_q;
	logic                     best_end_q;

	logic                     have_pend_q;
	logic [TRACK_W-1:0]       pend_track_q;
	logic [SEEK_W-1:0]        pend_total_q;

	logic                     visit_valid_q;
	logic [TRACK_W-1:0]       visit_track_q;
	logic [SEEK_W-1:0]        seek_total_q;
	logic                     seq_last_q;

	logic                     cur_dir;
	logic                     rd_done;
	logic                     s1_take;
	logic                     e_take;
	logic [TRACK_W-1:0]       end_track;
	logic [TRACK_COUNT_W-1:0] tc_minus1;
	logic [TRACK_W-1:0]       hop;
	logic [SEEK_W:0]          sum;
	logic [SEEK_W-1:0]        new_total;

	always_comb begin
		cur_dir = dir_q ^ pass_q;
		rd_done = (rd_idx_q == count_q);

		// A stored request belongs to the current sweep when it lies on that
		// sweep's side of the head position at batch start.
		s1_take = valid_s1 && !used_q[idx_s1]
			&& ((cur_dir == DIR_UP) ? (rdata_s1 > head_q) : (rdata_s1 < head_q))
			&& (!found_q || ((cur_dir == DIR_UP) ? (rdata_s1 < best_track_q)
				: (rdata_s1 > best_track_q)));

		// The end track joins only the first sweep.
		e_take = !pass_q && !end_used_q
			&& (!found_q || ((cur_dir == DIR_UP) ? (end_q < best_track_q)
				: (end_q > best_track_q)));

		tc_minus1 = track_count_q - TRACK_COUNT_W'(1);
		if (start_dir == DIR_DOWN) begin
			end_track = '0;
		end else if (track_count_q == '0) begin
			end_track = '0;
		end else if (tc_minus1[TRACK_COUNT_W-1]) begin
			end_track = '1;
		end else begin
			end_track = tc_minus1[TRACK_W-1:0];
		end

		hop       = (best_track_q > pos_q) ? (best_track_q - pos_q) : (pos_q - best_track_q);
		sum       = {1'b0, total_q} + {{(SEEK_W + 1 - TRACK_W){1'b0}}, hop};
		new_total = sum[SEEK_W] ? SEEK_MAX : sum[SEEK_W-1:0];

		status.scan_idle = !rd_run_q && !valid_s1;
		status.found     = found_q;
		status.last_pass = pass_q;
	end

	// Request store and its registered read port.
	always_ff @(posedge clk) begin
		if (cmd.accept_item && (count_q < CW'(MAX_REQUESTS))) begin
			req_mem[count_q[IW-1:0]] <= request_track;
		end
		rdata_s1 <= req_mem[rd_idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q <= TRACK_COUNT_RESET;
			count_q       <= '0;
			used_q        <= '0;
			end_used_q    <= 1'b0;
			pass_q        <= 1'b0;
			rd_run_q      <= 1'b0;
			rd_idx_q      <= '0;
			valid_s1      <= 1'b0;
			found_q       <= 1'b0;
			have_pend_q   <= 1'b0;
			visit_valid_q <= 1'b0;
		end else begin
			visit_valid_q <= 1'b0;
			if (cfg_we) begin
				track_count_q <= cfg_data;
			end
			if (cmd.accept_item && (count_q < CW'(MAX_REQUESTS))) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.begin_batch) begin
				used_q      <= '0;
				end_used_q  <= 1'b0;
				pass_q      <= 1'b0;
				have_pend_q <= 1'b0;
			end
			if (cmd.next_pass) begin
				pass_q <= 1'b1;
			end

			valid_s1 <= rd_run_q && !rd_done;
			if (cmd.scan_go) begin
				rd_run_q <= 1'b1;
				rd_idx_q <= '0;
			end else if (rd_run_q) begin
				if (rd_done) begin
					rd_run_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end

			priority if (cmd.scan_go) begin
				found_q <= 1'b0;
			end else if (s1_take || (cmd.merge && e_take)) begin
				found_q <= 1'b1;
			end

			if (cmd.take) begin
				if (best_end_q) begin
					end_used_q <= 1'b1;
				end else begin
					used_q[best_idx_q] <= 1'b1;
				end
				have_pend_q <= 1'b1;
				if (have_pend_q) begin
					visit_valid_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				visit_valid_q <= 1'b1;
				have_pend_q   <= 1'b0;
				count_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.begin_batch) begin
			head_q  <= head_track;
			dir_q   <= start_dir;
			end_q   <= end_track;
			pos_q   <= head_track;
			total_q <= '0;
		end
		idx_s1 <= rd_idx_q[IW-1:0];
		if (cmd.merge && e_take) begin
			best_track_q <= end_q;
			best_end_q   <= 1'b1;
		end else if (s1_take) begin
			best_track_q <= rdata_s1;
			best_idx_q   <= idx_s1;
			best_end_q   <= 1'b0;
		end
		if (cmd.take) begin
			pos_q        <= best_track_q;
			total_q      <= new_total;
			pend_track_q <= best_track_q;
			pend_total_q <= new_total;
			visit_track_q <= pend_track_q;
			seek_total_q  <= pend_total_q;
			seq_last_q    <= 1'b0;
		end
		if (cmd.finish) begin
			visit_track_q <= pend_track_q;
			seek_total_q  <= pend_total_q;
			seq_last_q    <= 1'b1;
		end
	end

	assign visit_valid = visit_valid_q;
	assign visit_track = visit_track_q;
	assign seek_total  = seek_total_q;
	assign seq_last    = seq_last_q;

	// A visit is only committed after a scan has found a candidate.
	a_take_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> found_q)
		else $error("visit committed without a candidate");

	// Every batch visits at least its end track, so a visit is held at the end.
	a_finish_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> have_pend_q)
		else $error("batch finished with no held visit");

	// A new scan never starts over a scan still in flight.
	a_scan_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_go |-> (!rd_run_q && !valid_s1))
		else $error("scan restarted while running");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REQUESTS))
		else $error("request count beyond store depth");

	// The finishing beat is the only one marked last.
	a_last_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(visit_valid_q && seq_last_q) |-> $past(cmd.finish))
		else $error("last flag without batch finish");

endmodule

/* src/scan_disk_scheduler.sv */
// Top level of the SCAN (elevator) disk scheduler.
// Instantiates sds_ctrl and sds_datapath; depends on sds_pkg.
//
//  Channel   Signals                                         Direction  Handshake
//  request   start, busy, request_track, head_track,         in         start && !busy
//            start_dir, batch_end
//  config    cfg_valid, cfg_ready, cfg_data                  in         cfg_valid && cfg_ready
//  result    visit_valid, visit_track, seek_total, seq_last  out        strobe, one cycle
//
// A request beat that does not end a batch is stored while the store has room and busy
// stays low. The beat that ends a batch starts scheduling in rounds: each round scans the
// request store (one entry a cycle through its registered read port) and then passes
// through a merge state and a commit state. Every visited track takes one round,
// switching the sweep direction takes one more, and a last round that finds nothing ends
// the batch. The last visit shows in the cycle after that final round, when busy is
// already low again.
// Reset clears the request count, the controller state and the result strobe;
// track_count returns to 200. The receiver cannot stall, so each result is shown once.
module scan_disk_scheduler
	import sds_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Request beats.
	input  logic                     start,
	output logic                     busy,
	input  logic [TRACK_W-1:0]       request_track,
	input  logic [TRACK_W-1:0]       head_track,
	input  logic                     start_dir,
	input  logic                     batch_end,
	// Track count register write.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [TRACK_COUNT_W-1:0] cfg_data,
	// Visited tracks.
	output logic                     visit_valid,
	output logic [TRACK_W-1:0]       visit_track,
	output logic [SEEK_W-1:0]        seek_total,
	output logic                     seq_last
);

	sds_cmd_t    cmd;
	sds_status_t status;
	logic        cfg_we;

	// The register is taken whenever busy is low, also while a batch is still being collected.
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	sds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.batch_end (batch_end),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// The datapath holds the store, walks it once per round to pick the nearest
	// request in the sweep direction, and holds each visit back by one step so
	// the final one can carry the last flag.
	sds_datapath #(
		.MAX_REQUESTS (MAX_REQUESTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.request_track (request_track),
		.head_track    (head_track),
		.start_dir     (start_dir),
		.visit_valid   (visit_valid),
		.visit_track   (visit_track),
		.seek_total    (seek_total),
		.seq_last      (seq_last)
	);

endmodule
